FILE: rtl/core/tpsc_pkg.sv
// Shared types, counter slot codes and the dosage combination table for the
// trio phase-switch counter core. No dependencies.

package tpsc_pkg;

  typedef struct packed {
    logic [7:0] trio_index;
    logic       child_left;
    logic       child_right;
    logic       child_phased;
    logic       father_left;
    logic       father_right;
    logic       father_phased;
    logic       mother_left;
    logic       mother_right;
    logic       mother_phased;
  } rec_t;

  typedef struct packed {
    logic [7:0]  trio_out;
    logic        mendel_error;
    logic        child_switched;
    logic        father_switched;
    logic        mother_switched;
    logic [31:0] mendel_total;
    logic [31:0] child_test_total;
    logic [31:0] child_switch_total;
    logic [31:0] father_switch_total;
    logic [31:0] mother_switch_total;
  } res_t;

  // One row of the combination table: error flag, tested members
  // (bit0 child, bit1 father, bit2 mother) and expected {left,right} pairs.
  typedef struct packed {
    logic       err;
    logic [2:0] tests;
    logic [1:0] cexp;
    logic [1:0] fexp;
    logic [1:0] mexp;
  } combo_t;

  // Member and counter slot codes within one state entry.
  localparam int MEMBER_CHILD  = 0;
  localparam int MEMBER_FATHER = 1;
  localparam int MEMBER_MOTHER = 2;
  localparam int NUM_MEMBERS   = 3;

  localparam int CNT_MENDEL  = 0;
  localparam int CNT_TEST0   = 1;  // child, father, mother tests follow
  localparam int CNT_SWITCH0 = 4;  // child, father, mother switches follow
  localparam int NUM_CNT     = 7;
  localparam int PHASE_BITS  = 3;

  // Index is father_dosage*9 + mother_dosage*3 + child_dosage.
  function automatic combo_t combo_lookup(input logic [4:0] idx);
    combo_t c;
    c = '{err: 1'b1, tests: 3'd0, cexp: 2'd0, fexp: 2'd0, mexp: 2'd0};
    unique case (idx)
      5'd0:  c = '{1'b0, 3'd0, 2'd0, 2'd0, 2'd0};
      5'd3:  c = '{1'b0, 3'd4, 2'd0, 2'd0, 2'd2};
      5'd4:  c = '{1'b0, 3'd5, 2'd1, 2'd0, 2'd1};
      5'd7:  c = '{1'b0, 3'd1, 2'd1, 2'd0, 2'd3};
      5'd9:  c = '{1'b0, 3'd2, 2'd0, 2'd1, 2'd0};
      5'd10: c = '{1'b0, 3'd3, 2'd2, 2'd2, 2'd0};
      5'd12: c = '{1'b0, 3'd6, 2'd0, 2'd1, 2'd2};
      5'd13: c = '{1'b0, 3'd0, 2'd0, 2'd0, 2'd0};
      5'd14: c = '{1'b0, 3'd6, 2'd3, 2'd2, 2'd1};
      5'd16: c = '{1'b0, 3'd3, 2'd1, 2'd1, 2'd3};
      5'd17: c = '{1'b0, 3'd2, 2'd3, 2'd2, 2'd3};
      5'd19: c = '{1'b0, 3'd3, 2'd2, 2'd3, 2'd0};
      5'd22: c = '{1'b0, 3'd5, 2'd2, 2'd3, 2'd2};
      5'd23: c = '{1'b0, 3'd4, 2'd3, 2'd3, 2'd1};
      5'd26: c = '{1'b0, 3'd0, 2'd0, 2'd0, 2'd0};
      default: c = '{err: 1'b1, tests: 3'd0, cexp: 2'd0, fexp: 2'd0, mexp: 2'd0};
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/tpsc_state_mem.sv
// Per-trio state memory: one synchronous read port, one write port.
// Valid bits per entry make never-written entries read as zero. Uses tpsc_pkg.

module tpsc_state_mem
  import tpsc_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 227
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] rd_q;
  logic              rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // an entry never written reads as its cleared value
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

FILE: rtl/core/tpsc_update.sv
// Read-modify logic for one record: combination lookup, Mendelian error and
// phase-switch checks, saturating counter updates. Uses tpsc_pkg.

module tpsc_update
  import tpsc_pkg::*;
#(
  parameter int COUNT_BITS = 32,
  parameter int DATA_W     = 227
) (
  input  rec_t              item,
  input  logic              in_range,
  input  logic [DATA_W-1:0] cur,
  output logic [DATA_W-1:0] nxt,
  output res_t              res
);

  logic [COUNT_BITS-1:0] cnt [NUM_CNT];
  logic [2:0]            phase;
  logic [2:0]            sw;
  logic [2:0]            phased;
  logic [1:0]            pair [NUM_MEMBERS];
  logic [1:0]            expect_pair [NUM_MEMBERS];
  logic [1:0]            cdose;
  logic [1:0]            fdose;
  logic [1:0]            mdose;
  logic [4:0]            idx;
  combo_t                combo;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [31:0] low32(input logic [COUNT_BITS-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[31:0];
  endfunction

  always_comb begin
    cdose = 2'(item.child_left) + 2'(item.child_right);
    fdose = 2'(item.father_left) + 2'(item.father_right);
    mdose = 2'(item.mother_left) + 2'(item.mother_right);
    idx   = 5'(5'(fdose) * 5'd9 + 5'(mdose) * 5'd3 + 5'(cdose));
    combo = combo_lookup(idx);

    phased = {item.mother_phased, item.father_phased, item.child_phased};
    pair[MEMBER_CHILD]         = {item.child_left, item.child_right};
    pair[MEMBER_FATHER]        = {item.father_left, item.father_right};
    pair[MEMBER_MOTHER]        = {item.mother_left, item.mother_right};
    expect_pair[MEMBER_CHILD]  = combo.cexp;
    expect_pair[MEMBER_FATHER] = combo.fexp;
    expect_pair[MEMBER_MOTHER] = combo.mexp;

    phase = cur[PHASE_BITS-1:0];
    for (int k = 0; k < NUM_CNT; k++) begin
      cnt[k] = cur[PHASE_BITS + k*COUNT_BITS +: COUNT_BITS];
    end

    sw = '0;
    if (combo.err) begin
      cnt[CNT_MENDEL] = sat_inc(cnt[CNT_MENDEL]);
    end else begin
      for (int m = 0; m < NUM_MEMBERS; m++) begin
        if (combo.tests[m] && phased[m]) begin
          cnt[CNT_TEST0 + m] = sat_inc(cnt[CNT_TEST0 + m]);
          // stored bit disagrees with expected phase: count a switch, toggle
          if ((pair[m] == expect_pair[m]) != phase[m]) begin
            sw[m]                = 1'b1;
            cnt[CNT_SWITCH0 + m] = sat_inc(cnt[CNT_SWITCH0 + m]);
            phase[m]             = ~phase[m];
          end
        end
      end
    end

    nxt[PHASE_BITS-1:0] = phase;
    for (int k = 0; k < NUM_CNT; k++) begin
      nxt[PHASE_BITS + k*COUNT_BITS +: COUNT_BITS] = cnt[k];
    end

    res          = '0;
    res.trio_out = item.trio_index;
    if (in_range) begin
      res.mendel_error        = combo.err;
      res.child_switched      = sw[MEMBER_CHILD];
      res.father_switched     = sw[MEMBER_FATHER];
      res.mother_switched     = sw[MEMBER_MOTHER];
      res.mendel_total        = low32(cnt[CNT_MENDEL]);
      res.child_test_total    = low32(cnt[CNT_TEST0 + MEMBER_CHILD]);
      res.child_switch_total  = low32(cnt[CNT_SWITCH0 + MEMBER_CHILD]);
      res.father_switch_total = low32(cnt[CNT_SWITCH0 + MEMBER_FATHER]);
      res.mother_switch_total = low32(cnt[CNT_SWITCH0 + MEMBER_MOTHER]);
    end
  end

endmodule

FILE: rtl/core/trio_phase_switch_counter_core.sv
// Top level of the trio phase-switch counter: read stage, modify/write-back
// stage with forwarding, and output register. Uses tpsc_pkg, tpsc_state_mem,
// tpsc_update.
//
//   port group      dir  payload  handshake
//   record          in   rec_t    record_valid / record_stall
//   result          out  res_t    result_valid / result_stall
//
// One record per cycle sustained while result_stall is low; a result is
// presented after its record is taken, the state memory read and record
// register at the transfer edge feeding modify and write-back into the
// output register. The single-port-per-direction state memory sets that rate.
// Synchronous reset clears the entry valid bits, so all counters read as
// zero at once; no clearing pass. A stall on result holds the output
// register and the modify stage, and record_stall rises once both are full.

module trio_phase_switch_counter_core
  import tpsc_pkg::*;
#(
  parameter int NUM_TRIOS  = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic record_valid,
  output logic record_stall,
  input  rec_t record,
  output logic result_valid,
  input  logic result_stall,
  output res_t result
);

  localparam int MEM_DEPTH = (NUM_TRIOS < 256) ? NUM_TRIOS : 256;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int DATA_W    = PHASE_BITS + NUM_CNT * COUNT_BITS;

  logic              accept;
  logic              rec_in_range;
  logic [ADDR_W-1:0] rec_addr;

  logic              s1_valid;
  rec_t              s1_item;
  logic              s1_in_range;
  logic              s1_fwd;
  logic              s1_adv;
  logic [ADDR_W-1:0] s1_addr;

  logic              wr_en;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] fwd_data;
  logic [DATA_W-1:0] cur;
  logic [DATA_W-1:0] nxt;
  res_t              upd_res;

  assign rec_in_range = 17'(record.trio_index) < 17'(NUM_TRIOS);
  assign rec_addr     = record.trio_index[ADDR_W-1:0];
  assign s1_addr      = s1_item.trio_index[ADDR_W-1:0];

  assign s1_adv       = !result_valid || !result_stall;
  assign record_stall = s1_valid && !s1_adv;
  assign accept       = record_valid && !record_stall;
  assign wr_en        = s1_valid && s1_adv && s1_in_range;

  // read issued in the same cycle as a write to that entry sees old data
  assign cur = s1_fwd ? fwd_data : rd_data;

  tpsc_state_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rec_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (nxt)
  );

  tpsc_update #(
    .COUNT_BITS (COUNT_BITS),
    .DATA_W     (DATA_W)
  ) u_update (
    .item     (s1_item),
    .in_range (s1_in_range),
    .cur      (cur),
    .nxt      (nxt),
    .res      (upd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item     <= record;
      s1_in_range <= rec_in_range;
      s1_fwd      <= wr_en && (s1_addr == rec_addr);
    end
    if (wr_en) begin
      fwd_data <= nxt;
    end
    if (s1_valid && s1_adv) begin
      result <= upd_res;
    end
  end

  // a Mendelian error never comes with a switch
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.mendel_error |->
      !(result.child_switched || result.father_switched || result.mother_switched))
    else $error("switch reported on a Mendelian error");

  // a child switch implies at least one child test
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.child_switched |-> result.child_test_total != 32'd0)
    else $error("child switch without a child test");

  // no record taken while the modify stage is held
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && result_valid && result_stall |-> !accept)
    else $error("record taken while modify stage held");

  // back-to-back writes to one entry never lose Mendelian or child test counts (forwarding check)
  assert property (@(posedge clk) disable iff (rst)
    wr_en && $past(wr_en) && (s1_addr == $past(s1_addr)) |->
      (nxt[PHASE_BITS + CNT_MENDEL*COUNT_BITS +: COUNT_BITS] >=
       $past(nxt[PHASE_BITS + CNT_MENDEL*COUNT_BITS +: COUNT_BITS])) &&
      (nxt[PHASE_BITS + CNT_TEST0*COUNT_BITS +: COUNT_BITS] >=
       $past(nxt[PHASE_BITS + CNT_TEST0*COUNT_BITS +: COUNT_BITS])))
    else $error("counter went backward across consecutive writes");

endmodule
